/* design/tctc_pkg.sv */
// Shared types, register offsets and mode bit positions of the three-channel counter/timer.
package tctc_pkg;

    // Number of counter channels and the index width that selects one of them.
    localparam int CHANNELS = 3;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Widths of the fields of a word.
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;
    localparam int IRQ_W   = 3;

    // Kinds of request word.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Register offsets within a channel.
    localparam logic [3:0] REG_COUNT  = 4'h0;
    localparam logic [3:0] REG_MODE   = 4'h4;
    localparam logic [3:0] REG_TARGET = 4'h8;

    // Mode register bit positions.
    localparam int MODE_RESET_ON_TARGET = 3;
    localparam int MODE_IRQ_TARGET      = 4;
    localparam int MODE_IRQ_MAX         = 5;
    localparam int MODE_IRQ_ENABLE      = 10;
    localparam int MODE_REACHED_TARGET  = 11;
    localparam int MODE_REACHED_MAX     = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [DATA_W-1:0]  BAD_READ  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  target_irq;
        logic [IRQ_W-1:0]  max_irq;
    } rsp_t;

endpackage

/* design/three_channel_target_counter_timer_top.sv */
// Three-channel 16-bit counter/timer with target compare, behind a simple register bus.
//
// Each request word is a tick, a register read or a register write. The low address
// byte selects the channel in bits 7:4 and the register in bits 3:0 (0 counter,
// 4 mode, 8 target). On a tick every channel counts up by one and wraps to zero either
// on reaching its target (mode bit 3 set) or on reaching 0xFFFF; the wrap sets the
// matching reached flag in mode (bit 11 target, bit 12 max) and raises a one-word
// interrupt pulse in the response when the matching enable (bit 4 or 5) and the
// global enable (bit 10) are set. Writing mode zeroes the counter, and reading mode
// returns it and then clears both reached flags. A read of a missing channel or an
// unknown offset returns all ones; such writes are dropped. Every request word gives
// exactly one response word. The whole update is done in the cycle the request is
// taken, with the channel state in flip-flops and the response held in an output
// register, so a new request word is taken every cycle;
// the only thing that holds the request side back is a response word that is still
// waiting in the output register while the response side stalls.
module three_channel_target_counter_timer_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tctc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tctc_pkg::rsp_t rsp
);

    // Channel state.
    logic [tctc_pkg::COUNT_W-1:0] count_reg   [tctc_pkg::CHANNELS];
    logic [tctc_pkg::COUNT_W-1:0] count_next  [tctc_pkg::CHANNELS];
    logic [tctc_pkg::DATA_W-1:0]  mode_reg    [tctc_pkg::CHANNELS];
    logic [tctc_pkg::DATA_W-1:0]  mode_next   [tctc_pkg::CHANNELS];
    logic [tctc_pkg::COUNT_W-1:0] target_reg  [tctc_pkg::CHANNELS];
    logic [tctc_pkg::COUNT_W-1:0] target_next [tctc_pkg::CHANNELS];

    // Output register.
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    tctc_pkg::rsp_t rsp_reg;
    tctc_pkg::rsp_t rsp_next;

    logic                          accept;
    logic                          ch_ok;
    logic [tctc_pkg::CH_W-1:0]     ch_idx;
    logic [3:0]                    offset;
    logic [tctc_pkg::COUNT_W-1:0]  inc;
    logic [tctc_pkg::CHANNELS+tctc_pkg::IRQ_W-1:0] tmask;
    logic [tctc_pkg::CHANNELS+tctc_pkg::IRQ_W-1:0] mmask;

    // The output register can take a new word when it is empty or being emptied.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign ch_ok  = {1'b0, req.address[7:4]} < 5'(tctc_pkg::CHANNELS);
    assign ch_idx = req.address[4 +: tctc_pkg::CH_W];
    assign offset = req.address[3:0];

    always_comb
    begin
        for (int c = 0; c < tctc_pkg::CHANNELS; c++)
        begin
            count_next[c]  = count_reg[c];
            mode_next[c]   = mode_reg[c];
            target_next[c] = target_reg[c];
        end
        tmask    = '0;
        mmask    = '0;
        inc      = '0;
        rsp_next = rsp_reg;
        rsp_next.read_data = '0;

        if (accept)
        begin
            case (req.kind)
                tctc_pkg::KIND_TICK:
                begin
                    // All channels advance in parallel.
                    for (int c = 0; c < tctc_pkg::CHANNELS; c++)
                    begin
                        inc = count_reg[c] + 16'd1;
                        if (mode_reg[c][tctc_pkg::MODE_RESET_ON_TARGET] &&
                            inc == target_reg[c])
                        begin
                            count_next[c] = '0;
                            mode_next[c][tctc_pkg::MODE_REACHED_TARGET] = 1'b1;
                            tmask[c] = mode_reg[c][tctc_pkg::MODE_IRQ_TARGET] &&
                                       mode_reg[c][tctc_pkg::MODE_IRQ_ENABLE];
                        end
                        else if (inc == tctc_pkg::COUNT_MAX)
                        begin
                            count_next[c] = '0;
                            mode_next[c][tctc_pkg::MODE_REACHED_MAX] = 1'b1;
                            mmask[c] = mode_reg[c][tctc_pkg::MODE_IRQ_MAX] &&
                                       mode_reg[c][tctc_pkg::MODE_IRQ_ENABLE];
                        end
                        else
                        begin
                            count_next[c] = inc;
                        end
                    end
                end
                tctc_pkg::KIND_READ:
                begin
                    rsp_next.read_data = tctc_pkg::BAD_READ;
                    if (ch_ok)
                    begin
                        case (offset)
                            tctc_pkg::REG_COUNT:
                                rsp_next.read_data = 32'(count_reg[ch_idx]);
                            tctc_pkg::REG_MODE:
                            begin
                                rsp_next.read_data = mode_reg[ch_idx];
                                mode_next[ch_idx][tctc_pkg::MODE_REACHED_TARGET] = 1'b0;
                                mode_next[ch_idx][tctc_pkg::MODE_REACHED_MAX]    = 1'b0;
                            end
                            tctc_pkg::REG_TARGET:
                                rsp_next.read_data = 32'(target_reg[ch_idx]);
                            default:
                                rsp_next.read_data = tctc_pkg::BAD_READ;
                        endcase
                    end
                end
                tctc_pkg::KIND_WRITE:
                begin
                    if (ch_ok)
                    begin
                        case (offset)
                            tctc_pkg::REG_COUNT:
                                count_next[ch_idx] = req.write_data[tctc_pkg::COUNT_W-1:0];
                            tctc_pkg::REG_MODE:
                            begin
                                mode_next[ch_idx]  = req.write_data;
                                count_next[ch_idx] = '0;
                            end
                            tctc_pkg::REG_TARGET:
                                target_next[ch_idx] = req.write_data[tctc_pkg::COUNT_W-1:0];
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase

            // Channels past the third have no interrupt bit.
            rsp_next.target_irq = tmask[tctc_pkg::IRQ_W-1:0];
            rsp_next.max_irq    = mmask[tctc_pkg::IRQ_W-1:0];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < tctc_pkg::CHANNELS; c++)
            begin
                count_reg[c]  <= '0;
                mode_reg[c]   <= '0;
                target_reg[c] <= '0;
            end
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            for (int c = 0; c < tctc_pkg::CHANNELS; c++)
            begin
                count_reg[c]  <= count_next[c];
                mode_reg[c]   <= mode_next[c];
                target_reg[c] <= target_next[c];
            end
        end
    end

    // The response payload needs no reset; it only loads with a taken request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // The request side is held back only by a waiting response word.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid_reg)
        else $error("request stalled while the output register is empty");

    // A write answers with an all-zero response word.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == tctc_pkg::KIND_WRITE) |=>
        (rsp_reg.read_data == '0 && rsp_reg.target_irq == '0 && rsp_reg.max_irq == '0))
        else $error("write produced a nonzero response word");

    // A mode write to an existing channel leaves its counter at zero.
    a_mode_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == tctc_pkg::KIND_WRITE && ch_ok &&
         offset == tctc_pkg::REG_MODE) |=> count_reg[$past(ch_idx)] == '0)
        else $error("mode write did not clear the counter");
`endif

endmodule
